// File: sv/button_autorepeat_deadzone_top_defines.svh
// assertion macros for the controller front end
`ifndef BUTTON_AUTOREPEAT_DEADZONE_TOP_DEFINES_SVH
`define BUTTON_AUTOREPEAT_DEADZONE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BARD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BARD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bard_pkg.sv
package bard_pkg;

  localparam int NUM_REPEAT_BUTTONS_DEF = 16;
  localparam int FIRED_W = 16;

  localparam logic [14:0] DEAD_ZONE_RESET = 15'd12288;
  localparam logic [7:0]  DELAY_RESET     = 8'd30;
  localparam logic [7:0]  INTERVAL_RESET  = 8'd0;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd2;

  typedef struct packed {
    logic [7:0] delay;
    logic [7:0] interval;
  } rpt_cfg_t;

endpackage

// File: sv/bard_in_if.sv
interface bard_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] buttons_now;
  logic [7:0]  left_x_byte;
  logic [7:0]  left_y_byte;
  logic [7:0]  right_x_byte;
  logic [7:0]  right_y_byte;

  modport source (
    output valid, buttons_now, left_x_byte, left_y_byte, right_x_byte, right_y_byte,
    input  ready
  );
  modport sink (
    input  valid, buttons_now, left_x_byte, left_y_byte, right_x_byte, right_y_byte,
    output ready
  );
endinterface

// File: sv/bard_out_if.sv
interface bard_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        buttons_raw;
  logic [31:0]        buttons_before;
  logic [15:0]        buttons_fired;
  logic signed [15:0] left_x_value;
  logic signed [15:0] left_y_value;
  logic signed [15:0] right_x_value;
  logic signed [15:0] right_y_value;

  modport source (
    output valid, buttons_raw, buttons_before, buttons_fired,
           left_x_value, left_y_value, right_x_value, right_y_value,
    input  ready
  );
  modport sink (
    input  valid, buttons_raw, buttons_before, buttons_fired,
           left_x_value, left_y_value, right_x_value, right_y_value,
    output ready
  );
endinterface

// File: sv/bard_cfg_if.sv
interface bard_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bard_pkg::CFG_IDX_W-1:0]      index;
  logic [bard_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/bard_cell.sv
module bard_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               pressed,
  input  bard_pkg::rpt_cfg_t cfg,
  output logic               fire
);

  logic [8:0] hold_r;
  logic [8:0] hold_nxt;
  logic [8:0] neg_mag;

  // hold_r: 0 released, positive counts toward first repeat, negative since last repeat
  always_comb begin
    neg_mag  = 9'd0 - hold_r;
    fire     = 1'b0;
    hold_nxt = hold_r;
    if (!pressed) begin
      hold_nxt = 9'd0;
    end else if (hold_r == 9'd0) begin
      hold_nxt = 9'd1;
      fire     = 1'b1;
    end else if (!hold_r[8]) begin
      if (hold_r[7:0] >= cfg.delay) begin
        hold_nxt = 9'h1FF;
        fire     = 1'b1;
      end else begin
        hold_nxt = hold_r + 9'd1;
      end
    end else begin
      if (neg_mag > {1'b0, cfg.interval}) begin
        hold_nxt = 9'h1FF;
        fire     = 1'b1;
      end else begin
        hold_nxt = hold_r - 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 9'd0;
    end else if (adv) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

// File: sv/bard_stick.sv
module bard_stick (
  input  logic [7:0]         raw_byte,
  input  logic [14:0]        dead_zone,
  output logic signed [15:0] value
);

  logic [7:0]  centred;
  logic [7:0]  mag;
  logic [15:0] mag_scaled;

  // byte minus 128 is the byte with its top bit flipped
  always_comb begin
    centred    = {~raw_byte[7], raw_byte[6:0]};
    mag        = centred[7] ? (8'd0 - centred) : centred;
    mag_scaled = {mag, 8'h00};
    if (mag_scaled < {1'b0, dead_zone}) begin
      value = 16'sd0;
    end else begin
      value = {centred, 8'h00};
    end
  end

endmodule

// File: sv/button_autorepeat_deadzone_top.sv
// Controller front end: button auto-repeat and stick dead zone.
// in_ch carries one controller sample per transaction: a 32-bit button word
// and four stick bytes. out_ch returns one result per sample: the raw word,
// the previous sample's word, a 16-bit fire word and four centred stick values.
// cfg_ch writes dead_zone (index 0), repeat_delay (1) and repeat_interval (2);
// other indexes are ignored. cfg_ch.ready is always high; write only when idle.
// An accepted sample passes through the input and result registers to out_ch.
// Throughput: one sample per cycle unless out_ch stalls; an input register and a
// result register with the per-button counters and stick logic between them.
// A stalled out_ch holds its result; the input register still takes one more
// sample, then in_ch.ready drops until out_ch.ready returns.
// Reset clears all hold counters, the previous-word register and both valid
// flags, and loads dead_zone 12288, repeat_delay 30, repeat_interval 0.
`include "button_autorepeat_deadzone_top_defines.svh"

module button_autorepeat_deadzone_top #(
  parameter int NUM_REPEAT_BUTTONS = bard_pkg::NUM_REPEAT_BUTTONS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bard_in_if.sink    in_ch,
  bard_out_if.source out_ch,
  bard_cfg_if.sink   cfg_ch
);

  logic [14:0]        dead_zone_r;
  bard_pkg::rpt_cfg_t rpt_cfg_r;

  logic        s1_valid_r;
  logic [31:0] s1_buttons_r;
  logic [7:0]  s1_lx_r;
  logic [7:0]  s1_ly_r;
  logic [7:0]  s1_rx_r;
  logic [7:0]  s1_ry_r;
  logic [31:0] last_buttons_r;

  logic               out_valid_r;
  logic [31:0]        out_raw_r;
  logic [31:0]        out_before_r;
  logic [15:0]        out_fired_r;
  logic signed [15:0] out_lx_r;
  logic signed [15:0] out_ly_r;
  logic signed [15:0] out_rx_r;
  logic signed [15:0] out_ry_r;

  logic adv;
  logic adv_item;
  logic in_accept;

  logic [NUM_REPEAT_BUTTONS-1:0] fire_all;
  logic [bard_pkg::FIRED_W-1:0]  fired_nxt;
  logic signed [15:0]            lx_nxt;
  logic signed [15:0]            ly_nxt;
  logic signed [15:0]            rx_nxt;
  logic signed [15:0]            ry_nxt;

  assign adv          = !out_valid_r || out_ch.ready;
  assign adv_item     = adv && s1_valid_r;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r        <= bard_pkg::DEAD_ZONE_RESET;
      rpt_cfg_r.delay    <= bard_pkg::DELAY_RESET;
      rpt_cfg_r.interval <= bard_pkg::INTERVAL_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bard_pkg::CFG_DEAD_ZONE:       dead_zone_r        <= cfg_ch.data[14:0];
        bard_pkg::CFG_REPEAT_DELAY:    rpt_cfg_r.delay    <= cfg_ch.data[7:0];
        bard_pkg::CFG_REPEAT_INTERVAL: rpt_cfg_r.interval <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_buttons_r <= in_ch.buttons_now;
      s1_lx_r      <= in_ch.left_x_byte;
      s1_ly_r      <= in_ch.left_y_byte;
      s1_rx_r      <= in_ch.right_x_byte;
      s1_ry_r      <= in_ch.right_y_byte;
    end
  end

  // per-button repeat counters
  genvar gi;
  generate
    for (gi = 0; gi < NUM_REPEAT_BUTTONS; gi++) begin : g_cell
      bard_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv_item),
        .pressed (s1_buttons_r[gi]),
        .cfg     (rpt_cfg_r),
        .fire    (fire_all[gi])
      );
    end
    for (gi = 0; gi < bard_pkg::FIRED_W; gi++) begin : g_fired
      if (gi < NUM_REPEAT_BUTTONS) begin : g_used
        assign fired_nxt[gi] = fire_all[gi];
      end else begin : g_unused
        assign fired_nxt[gi] = 1'b0;
      end
    end
  endgenerate

  bard_stick u_lx (.raw_byte(s1_lx_r), .dead_zone(dead_zone_r), .value(lx_nxt));
  bard_stick u_ly (.raw_byte(s1_ly_r), .dead_zone(dead_zone_r), .value(ly_nxt));
  bard_stick u_rx (.raw_byte(s1_rx_r), .dead_zone(dead_zone_r), .value(rx_nxt));
  bard_stick u_ry (.raw_byte(s1_ry_r), .dead_zone(dead_zone_r), .value(ry_nxt));

  // result register and previous word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      last_buttons_r <= 32'd0;
    end else begin
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (adv_item) begin
        last_buttons_r <= s1_buttons_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_item) begin
      out_raw_r    <= s1_buttons_r;
      out_before_r <= last_buttons_r;
      out_fired_r  <= fired_nxt;
      out_lx_r     <= lx_nxt;
      out_ly_r     <= ly_nxt;
      out_rx_r     <= rx_nxt;
      out_ry_r     <= ry_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.buttons_raw    = out_raw_r;
  assign out_ch.buttons_before = out_before_r;
  assign out_ch.buttons_fired  = out_fired_r;
  assign out_ch.left_x_value   = out_lx_r;
  assign out_ch.left_y_value   = out_ly_r;
  assign out_ch.right_x_value  = out_rx_r;
  assign out_ch.right_y_value  = out_ry_r;

  `BARD_ASSERT_IMP(a_full_blocks_input, s1_valid_r && !adv, !in_ch.ready, "input taken while full")
  `BARD_ASSERT_NXT(a_item_reaches_out, adv_item, out_valid_r, "item lost on its way out")
  `BARD_ASSERT_IMP(a_fire_needs_press, out_valid_r, (out_fired_r & ~out_raw_r[15:0]) == 16'd0, "fire on released button")
  `BARD_ASSERT_NXT(a_before_tracks_raw, adv_item, last_buttons_r == out_raw_r, "previous word out of step")

endmodule
